>>> hdl/bridged_pwm_tone_generator_top_assert.svh
// assertion macros shared by the tone generator modules
// both expect clk and rst_n in the scope where they are used
`ifndef BRIDGED_PWM_TONE_GENERATOR_TOP_ASSERT_SVH
`define BRIDGED_PWM_TONE_GENERATOR_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define BPTG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define BPTG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BPTG_ASSERT_IMP(lbl, ante, cons, msg)

`define BPTG_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

>>> hdl/bptg_pkg.sv
package bptg_pkg;

  localparam int MODE_W    = 2;
  localparam int FREQ_W    = 16;
  localparam int VOL_W     = 4;
  localparam int LEN_W     = 32;
  localparam int TOP_W     = 16;
  localparam int RATE_W    = 24;
  localparam int TPM_W     = 16;
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SET  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STOP = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_TOP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TPM  = 2'd2;

  localparam logic [TOP_W-1:0]  TOP_RST  = 16'd79;
  localparam logic [RATE_W-1:0] RATE_RST = 24'd200000;
  localparam logic [TPM_W-1:0]  TPM_RST  = 16'd16000;
  localparam logic [TOP_W-1:0]  TOP_MIN  = 16'd2;

  localparam logic [VOL_W-1:0] VOL_MAX = 4'd10;

  localparam int TIMER_WIDTH_DEF = 16;

  // divider: 24 bit dividend, 17 bit divisor
  localparam int DIVD_W    = 24;
  localparam int DIVS_W    = 17;
  localparam int DIV_CNT_W = $clog2(DIVD_W);

  // duty divide by ten: multiply by ceil(2^23 / 10), exact below 2^22
  localparam int DUTY_W     = 20;
  localparam int DUTY_MUL_W = 40;
  localparam int DUTY_SHIFT = 23;
  localparam logic [DUTY_W-1:0] DUTY_RECIP = 20'd838861;

  typedef struct packed {
    logic              valid;
    logic [MODE_W-1:0] op;
    logic              vol_zero;
    logic              len_zero;
    logic              timed;
    logic [LEN_W-1:0]  length_ms;
    logic [TOP_W-1:0]  duty;
  } tone_cmd_t;

  typedef struct packed {
    logic pin_a;
    logic pin_b;
    logic playing;
  } tone_stat_t;

endpackage

>>> hdl/bptg_div.sv
`include "bridged_pwm_tone_generator_top_assert.svh"

module bptg_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [bptg_pkg::DIVD_W-1:0]   dividend,
  input  logic [bptg_pkg::DIVS_W-1:0]   divisor,
  output logic                          done,
  output logic [bptg_pkg::DIVD_W-1:0]   quotient
);
  import bptg_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIVD_W-1:0]    q_r, q_nxt;
  logic [DIVS_W-1:0]    rem_r, rem_nxt;
  logic [DIVS_W-1:0]    dvs_r, dvs_nxt;
  logic [DIVS_W:0]      trial;
  logic [DIVS_W:0]      diff;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, q_r[DIVD_W-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      q_nxt    = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = diff[DIVS_W-1:0];
        q_nxt   = {q_r[DIVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DIVS_W-1:0];
        q_nxt   = {q_r[DIVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

  `BPTG_ASSERT_NXT(a_start_busy, start, busy_r, "divider not busy after start")
  `BPTG_ASSERT_NXT(a_done_idle, done_r, !busy_r || $past(start), "divider busy after done")

endmodule

>>> hdl/bptg_tone.sv
`include "bridged_pwm_tone_generator_top_assert.svh"

module bptg_tone #(
  parameter int TIMER_WIDTH = bptg_pkg::TIMER_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bptg_pkg::tone_cmd_t         cmd,
  input  logic [TIMER_WIDTH-1:0]      divisor,
  input  logic [bptg_pkg::TOP_W-1:0]  top_eff,
  input  logic [bptg_pkg::TPM_W-1:0]  tpm_eff,
  output bptg_pkg::tone_stat_t        stat
);
  import bptg_pkg::*;

  logic                   running_r, running_nxt;
  logic                   phase_a_r, phase_a_nxt;
  logic [TOP_W-1:0]       pwm_r, pwm_nxt;
  logic [TOP_W-1:0]       duty_r, duty_nxt;
  logic [TIMER_WIDTH-1:0] div_r, div_nxt;
  logic [TIMER_WIDTH-1:0] divcnt_r, divcnt_nxt;
  logic                   timed_r, timed_nxt;
  logic [LEN_W-1:0]       remain_r, remain_nxt;
  logic [TPM_W-1:0]       presc_r, presc_nxt;
  logic [LEN_W-1:0]       remain_dec;
  logic                   high;

  always_comb begin
    running_nxt = running_r;
    phase_a_nxt = phase_a_r;
    pwm_nxt     = pwm_r;
    duty_nxt    = duty_r;
    div_nxt     = div_r;
    divcnt_nxt  = divcnt_r;
    timed_nxt   = timed_r;
    remain_nxt  = remain_r;
    presc_nxt   = presc_r;
    remain_dec  = remain_r;
    if (cmd.valid) begin
      unique case (cmd.op)
        MODE_TICK: begin
          if (running_r) begin
            if (pwm_r >= top_eff) begin
              pwm_nxt = '0;
              if (divcnt_r == div_r) begin
                phase_a_nxt = !phase_a_r;
                divcnt_nxt  = '0;
              end else begin
                divcnt_nxt = divcnt_r + {{(TIMER_WIDTH-1){1'b0}}, 1'b1};
              end
            end else begin
              pwm_nxt = pwm_r + 1'b1;
            end
            if (timed_r) begin
              presc_nxt = presc_r + 1'b1;
              if (presc_nxt >= tpm_eff) begin
                presc_nxt = '0;
                if (remain_r != '0) begin
                  remain_dec = remain_r - 1'b1;
                end
                remain_nxt = remain_dec;
                if (remain_dec == '0) begin
                  running_nxt = 1'b0;
                  timed_nxt   = 1'b0;
                end
              end
            end
          end
        end
        MODE_SET: begin
          duty_nxt = cmd.duty;
          if (!cmd.timed) begin
            if (cmd.vol_zero) begin
              running_nxt = 1'b0;
              timed_nxt   = 1'b0;
            end else begin
              div_nxt = divisor;
              if (!running_r) begin
                running_nxt = 1'b1;
                phase_a_nxt = 1'b1;
                divcnt_nxt  = '0;
                pwm_nxt     = '0;
              end
              timed_nxt = 1'b0;
            end
          end else if (cmd.vol_zero || cmd.len_zero) begin
            running_nxt = 1'b0;
            timed_nxt   = 1'b0;
          end else if (!running_r) begin
            // timed request while playing only changes the volume
            div_nxt     = divisor;
            running_nxt = 1'b1;
            phase_a_nxt = 1'b1;
            divcnt_nxt  = '0;
            pwm_nxt     = '0;
            timed_nxt   = 1'b1;
            remain_nxt  = cmd.length_ms;
            presc_nxt   = '0;
          end
        end
        MODE_STOP: begin
          running_nxt = 1'b0;
          timed_nxt   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      phase_a_r <= 1'b1;
      pwm_r     <= '0;
      duty_r    <= TOP_RST;
      div_r     <= '0;
      divcnt_r  <= '0;
      timed_r   <= 1'b0;
      remain_r  <= '0;
      presc_r   <= '0;
    end else begin
      running_r <= running_nxt;
      phase_a_r <= phase_a_nxt;
      pwm_r     <= pwm_nxt;
      duty_r    <= duty_nxt;
      div_r     <= div_nxt;
      divcnt_r  <= divcnt_nxt;
      timed_r   <= timed_nxt;
      remain_r  <= remain_nxt;
      presc_r   <= presc_nxt;
    end
  end

  assign high         = running_r && (pwm_r <= duty_r);
  assign stat.pin_a   = high && phase_a_r;
  assign stat.pin_b   = high && !phase_a_r;
  assign stat.playing = running_r;

  `BPTG_ASSERT_IMP(a_quiet_stopped, !running_r, !stat.pin_a && !stat.pin_b,
                   "pin driven while stopped")
  `BPTG_ASSERT_IMP(a_timed_running, timed_r, running_r, "timed countdown without tone")

endmodule

>>> hdl/bridged_pwm_tone_generator_top.sv
// push-pull pwm tone generator, two bridge pins plus a playing flag
// input channel: in_valid / in_stall with mode, frequency, volume, length_ms
// and timed; every accepted item gives exactly one result on out_valid /
// out_stall carrying the pin levels and the playing flag after that item
// a clock tick, stop or unused item updates the tone on its accept, passes
// through the output state into the result register, and the next item is
// taken once the block is back in idle
// a set tone item passes through the duty steps (volume product, then a multiply
// by one tenth), a start state and 24 steps of the bit-serial divider for the
// tone divisor, then the tone update and the result register; in_stall stays
// high meanwhile
// configuration: cfg_we with cfg_index and cfg_wdata writes pwm top, overflow
// rate or ticks per millisecond; write only while idle
// reset (rst_n low, synchronous) stops the tone, loads the default
// configuration and empties the result register
// a stalled result holds on the output; the block finishes the next item's
// work and then waits until the result register frees up
`include "bridged_pwm_tone_generator_top_assert.svh"

module bridged_pwm_tone_generator_top #(
  parameter int TIMER_WIDTH = bptg_pkg::TIMER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [bptg_pkg::MODE_W-1:0]     in_mode,
  input  logic [bptg_pkg::FREQ_W-1:0]     in_frequency,
  input  logic [bptg_pkg::VOL_W-1:0]      in_volume,
  input  logic [bptg_pkg::LEN_W-1:0]      in_length_ms,
  input  logic                            in_timed,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_pin_a,
  output logic                            out_pin_b,
  output logic                            out_playing,
  input  logic                            cfg_we,
  input  logic [bptg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bptg_pkg::CFG_W-1:0]      cfg_wdata
);
  import bptg_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DUTY_ST = 3'd1;
  localparam logic [2:0] S_DUTY_WT = 3'd2;
  localparam logic [2:0] S_FREQ_ST = 3'd3;
  localparam logic [2:0] S_FREQ_WT = 3'd4;
  localparam logic [2:0] S_OUT     = 3'd5;

  localparam logic [32:0] TMAX = (33'd1 << TIMER_WIDTH) - 33'd1;

  logic [2:0]        state_r, state_nxt;
  logic [TOP_W-1:0]  top_r;
  logic [RATE_W-1:0] rate_r;
  logic [TPM_W-1:0]  tpm_r;
  logic [TOP_W-1:0]  top_eff;
  logic [TPM_W-1:0]  tpm_eff;

  logic [FREQ_W-1:0] freq_r;
  logic [VOL_W-1:0]  vol_r;
  logic [LEN_W-1:0]  len_r;
  logic              timed_r;
  logic [TOP_W-1:0]  duty_r, duty_nxt;

  logic              out_valid_r, out_valid_nxt;
  tone_stat_t        out_stat_r;
  logic              out_free;
  logic              accept;

  logic [VOL_W-1:0]      vol_sat;
  logic [DUTY_W-1:0]     duty_prod;
  logic [DUTY_W-1:0]     duty_prod_r;
  logic [DUTY_MUL_W-1:0] duty_recip;
  logic [FREQ_W-1:0] freq_eff;
  logic              div_start;
  logic [DIVD_W-1:0] div_dividend;
  logic [DIVS_W-1:0] div_divisor;
  logic              div_done;
  logic [DIVD_W-1:0] div_quot;
  logic [DIVD_W-1:0] tone_q;
  logic [32:0]       tone_d;
  logic [TIMER_WIDTH-1:0] tone_div;

  tone_cmd_t         cmd;
  tone_stat_t        stat;

  assign top_eff  = (top_r < TOP_MIN) ? TOP_MIN : top_r;
  assign tpm_eff  = (tpm_r == '0) ? TPM_W'(1) : tpm_r;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // duty operand: saturated volume times (top - 1), fits in 20 bits
  assign vol_sat    = (vol_r > VOL_MAX) ? VOL_MAX : vol_r;
  assign duty_prod  = DUTY_W'(vol_sat) * DUTY_W'(top_eff - 1'b1);
  assign duty_recip = DUTY_MUL_W'(duty_prod_r) * DUTY_MUL_W'(DUTY_RECIP);
  assign freq_eff   = (freq_r == '0) ? FREQ_W'(1) : freq_r;

  assign div_start    = (state_r == S_FREQ_ST);
  assign div_dividend = rate_r;
  assign div_divisor  = {freq_eff, 1'b0};

  // tone divisor: quotient minus one, floored at zero, saturated to the timer
  assign tone_q   = div_quot;
  assign tone_d   = (tone_q == '0) ? 33'd0 : 33'(tone_q - 1'b1);
  assign tone_div = (tone_d > TMAX) ? TMAX[TIMER_WIDTH-1:0] : tone_d[TIMER_WIDTH-1:0];

  bptg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_comb begin
    cmd.valid     = (accept && in_mode != MODE_SET) || (state_r == S_FREQ_WT && div_done);
    cmd.op        = (state_r == S_IDLE) ? in_mode : MODE_SET;
    cmd.vol_zero  = (vol_r == '0);
    cmd.len_zero  = (len_r == '0);
    cmd.timed     = timed_r;
    cmd.length_ms = len_r;
    cmd.duty      = duty_r;
  end

  bptg_tone #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_tone (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .divisor (tone_div),
    .top_eff (top_eff),
    .tpm_eff (tpm_eff),
    .stat    (stat)
  );

  always_comb begin
    state_nxt     = state_r;
    duty_nxt      = duty_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_mode == MODE_SET) ? S_DUTY_ST : S_OUT;
        end
      end
      S_DUTY_ST: state_nxt = S_DUTY_WT;
      S_DUTY_WT: begin
        duty_nxt  = duty_recip[DUTY_SHIFT +: TOP_W] + 1'b1;
        state_nxt = S_FREQ_ST;
      end
      S_FREQ_ST: state_nxt = S_FREQ_WT;
      S_FREQ_WT: begin
        if (div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      top_r       <= TOP_RST;
      rate_r      <= RATE_RST;
      tpm_r       <= TPM_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TOP:  top_r  <= cfg_wdata[TOP_W-1:0];
          CFG_RATE: rate_r <= cfg_wdata[RATE_W-1:0];
          CFG_TPM:  tpm_r  <= cfg_wdata[TPM_W-1:0];
          default: begin
          end
        endcase
      end
    end
    duty_r <= duty_nxt;
    if (state_r == S_DUTY_ST) begin
      duty_prod_r <= duty_prod;
    end
    if (accept) begin
      freq_r  <= in_frequency;
      vol_r   <= in_volume;
      len_r   <= in_length_ms;
      timed_r <= in_timed;
    end
    if (state_r == S_OUT && out_free) begin
      out_stat_r <= stat;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pin_a   = out_stat_r.pin_a;
  assign out_pin_b   = out_stat_r.pin_b;
  assign out_playing = out_stat_r.playing;

  `BPTG_ASSERT_IMP(a_done_in_wait, div_done, state_r == S_FREQ_WT,
                   "divider result outside a wait state")

endmodule
